// ===== hdl/ptw_pkg.sv =====
// ----------------------------------------------------------------------------
// ptw_pkg
// Shared constants, types and the control program of the page-table walker.
// ----------------------------------------------------------------------------
package ptw_pkg;

  // Number of 64-bit table words held in the store. It must be a power of two
  // so that table addresses wrap by simple truncation.
  localparam int STORE_WORDS = 4096;
  localparam int ADDR_W      = $clog2(STORE_WORDS);

  localparam int ENTRY_W   = 64;
  localparam int PA_W      = 52;
  localparam int VA_W      = 48;
  localparam int IDX_W     = 9;
  localparam int OFF_W     = 12;
  localparam int FRAME_LO  = 12;
  localparam int FRAME_W   = PA_W - FRAME_LO;
  localparam int WADDR_W   = 12;
  localparam int WORD_W    = FRAME_W + IDX_W;
  localparam int PRESENT_BIT = 0;

  // Steps of the control program.
  typedef enum logic [2:0] {
    ST_CLEAR = 3'd0,
    ST_IDLE  = 3'd1,
    ST_WRITE = 3'd2,
    ST_WALK  = 3'd3,
    ST_CHK0  = 3'd4,
    ST_CHK1  = 3'd5,
    ST_CHK2  = 3'd6,
    ST_CHK3  = 3'd7
  } step_t;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } ram_op_t;

  typedef enum logic {
    SRC_ROOT  = 1'b0,
    SRC_ENTRY = 1'b1
  } addr_src_t;

  typedef enum logic [1:0] {
    RES_NONE  = 2'd0,
    RES_WRITE = 2'd1,
    RES_LEAF  = 2'd2
  } result_t;

  typedef enum logic [1:0] {
    COND_NEVER      = 2'd0,
    COND_WRITE_MODE = 2'd1,
    COND_CLEARING   = 2'd2,
    COND_MISSING    = 2'd3
  } cond_t;

  typedef struct packed {
    logic      busy;
    logic      wait_start;
    ram_op_t   ram_op;
    addr_src_t addr_src;
    logic [1:0] rd_level;
    logic      check;
    logic [1:0] chk_level;
    result_t   result;
    cond_t     cond;
    step_t     nxt;
    step_t     alt;
  } ctrl_word_t;

  typedef struct packed {
    logic start;
    logic mode;
    logic missing;
    logic clear_last;
  } seq_status_t;

  // The control store. A step goes to alt when its condition holds, else to nxt.
  function automatic ctrl_word_t ucode_word(step_t step);
    ctrl_word_t w;
    case (step)
      ST_CLEAR: w = '{1'b1, 1'b0, OP_CLEAR, SRC_ROOT, 2'd0, 1'b0, 2'd0,
                      RES_NONE, COND_CLEARING, ST_IDLE, ST_CLEAR};
      ST_IDLE:  w = '{1'b0, 1'b1, OP_NONE, SRC_ROOT, 2'd0, 1'b0, 2'd0,
                      RES_NONE, COND_WRITE_MODE, ST_WALK, ST_WRITE};
      ST_WRITE: w = '{1'b1, 1'b0, OP_WRITE, SRC_ROOT, 2'd0, 1'b0, 2'd0,
                      RES_WRITE, COND_NEVER, ST_IDLE, ST_IDLE};
      ST_WALK:  w = '{1'b1, 1'b0, OP_READ, SRC_ROOT, 2'd0, 1'b0, 2'd0,
                      RES_NONE, COND_NEVER, ST_CHK0, ST_CHK0};
      ST_CHK0:  w = '{1'b1, 1'b0, OP_READ, SRC_ENTRY, 2'd1, 1'b1, 2'd0,
                      RES_NONE, COND_MISSING, ST_CHK1, ST_IDLE};
      ST_CHK1:  w = '{1'b1, 1'b0, OP_READ, SRC_ENTRY, 2'd2, 1'b1, 2'd1,
                      RES_NONE, COND_MISSING, ST_CHK2, ST_IDLE};
      ST_CHK2:  w = '{1'b1, 1'b0, OP_READ, SRC_ENTRY, 2'd3, 1'b1, 2'd2,
                      RES_NONE, COND_MISSING, ST_CHK3, ST_IDLE};
      ST_CHK3:  w = '{1'b1, 1'b0, OP_NONE, SRC_ENTRY, 2'd0, 1'b1, 2'd3,
                      RES_LEAF, COND_NEVER, ST_IDLE, ST_IDLE};
      default:  w = '{1'b1, 1'b0, OP_NONE, SRC_ROOT, 2'd0, 1'b0, 2'd0,
                      RES_NONE, COND_NEVER, ST_IDLE, ST_IDLE};
    endcase
    return w;
  endfunction

  // Nine-bit table index of one level, top level first.
  function automatic logic [IDX_W-1:0] va_index(logic [VA_W-1:0] va, logic [1:0] level);
    logic [IDX_W-1:0] idx;
    case (level)
      2'd0:    idx = va[47:39];
      2'd1:    idx = va[38:30];
      2'd2:    idx = va[29:21];
      2'd3:    idx = va[20:12];
      default: idx = va[47:39];
    endcase
    return idx;
  endfunction

  // Word index of an entry: table frame in words plus the index, wrapped.
  function automatic logic [ADDR_W-1:0] table_word(logic [FRAME_W-1:0] frame,
                                                   logic [IDX_W-1:0] idx);
    logic [WORD_W-1:0] w;
    w = {frame, idx};
    return w[ADDR_W-1:0];
  endfunction

endpackage

// ===== hdl/ptw_ram.sv =====
// ----------------------------------------------------------------------------
// ptw_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ptw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/ptw_seq.sv =====
// ----------------------------------------------------------------------------
// ptw_seq
// Step counter of the walker: fetches the control word of the current step
// and picks the next step from the word's condition and targets.
// ----------------------------------------------------------------------------
module ptw_seq (
  input  logic                clk,
  input  logic                rst,
  input  ptw_pkg::seq_status_t status,
  output ptw_pkg::ctrl_word_t  cw
);

  ptw_pkg::step_t pc;
  ptw_pkg::step_t pc_next;
  logic           cond_true;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= ptw_pkg::ST_CLEAR;
    end else begin
      pc <= pc_next;
    end
  end

  always_comb begin
    cw = ptw_pkg::ucode_word(pc);
    case (cw.cond)
      ptw_pkg::COND_NEVER:      cond_true = 1'b0;
      ptw_pkg::COND_WRITE_MODE: cond_true = !status.mode;
      ptw_pkg::COND_CLEARING:   cond_true = !status.clear_last;
      ptw_pkg::COND_MISSING:    cond_true = status.missing;
      default:                  cond_true = 1'b0;
    endcase
    if (cw.wait_start && !status.start) begin
      pc_next = pc;
    end else if (cond_true) begin
      pc_next = cw.alt;
    end else begin
      pc_next = cw.nxt;
    end
  end

endmodule

// ===== hdl/ptw_dp.sv =====
// ----------------------------------------------------------------------------
// ptw_dp
// Datapath of the walker: item latches, root register, table store, entry
// address formation and the result registers.
// ----------------------------------------------------------------------------
module ptw_dp (
  input  logic                                 clk,
  input  logic                                 rst,
  input  ptw_pkg::ctrl_word_t                  cw,
  input  logic                                 accept,
  input  logic [ptw_pkg::WADDR_W-1:0]          word_address,
  input  logic [ptw_pkg::ENTRY_W-1:0]          write_data,
  input  logic [ptw_pkg::VA_W-1:0]             virtual_address,
  input  logic                                 root_we,
  input  logic [ptw_pkg::PA_W-1:0]             root_table_address,
  output logic                                 missing,
  output logic                                 clear_last,
  output logic                                 done,
  output logic [ptw_pkg::PA_W-1:0]             physical_address,
  output logic                                 fault,
  output logic [1:0]                           fault_level
);

  logic [ptw_pkg::WADDR_W-1:0] waddr_q;
  logic [ptw_pkg::ENTRY_W-1:0] wdata_q;
  logic [ptw_pkg::VA_W-1:0]    va_q;
  logic [ptw_pkg::PA_W-1:0]    root;
  logic [ptw_pkg::ADDR_W-1:0]  clr_cnt;

  logic                        ram_we;
  logic [ptw_pkg::ADDR_W-1:0]  ram_waddr;
  logic [ptw_pkg::ENTRY_W-1:0] ram_wdata;
  logic                        ram_re;
  logic [ptw_pkg::ADDR_W-1:0]  ram_raddr;
  logic [ptw_pkg::ENTRY_W-1:0] ram_rdata;
  logic [ptw_pkg::FRAME_W-1:0] frame_sel;
  logic [ptw_pkg::WORD_W-1:0]  waddr_wide;

  logic load_fault;
  logic load_ok;

  always_ff @(posedge clk) begin
    if (accept) begin
      waddr_q <= word_address;
      wdata_q <= write_data;
      va_q    <= virtual_address;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      root <= '0;
    end else if (root_we) begin
      root <= root_table_address;
    end
  end

  // The clearing pass after reset walks the store one word per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cw.ram_op == ptw_pkg::OP_CLEAR) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  assign clear_last = (clr_cnt == ptw_pkg::ADDR_W'(ptw_pkg::STORE_WORDS - 1));
  assign waddr_wide = ptw_pkg::WORD_W'(waddr_q);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_cnt;
    ram_wdata = '0;
    case (cw.ram_op)
      ptw_pkg::OP_CLEAR: begin
        ram_we = 1'b1;
      end
      ptw_pkg::OP_WRITE: begin
        ram_we    = 1'b1;
        ram_waddr = waddr_wide[ptw_pkg::ADDR_W-1:0];
        ram_wdata = wdata_q;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Next table comes from the root register on the first read, then from
  // the frame bits of the entry that was just read.
  assign frame_sel = (cw.addr_src == ptw_pkg::SRC_ROOT) ?
                     root[ptw_pkg::PA_W-1:ptw_pkg::FRAME_LO] :
                     ram_rdata[ptw_pkg::PA_W-1:ptw_pkg::FRAME_LO];
  assign ram_re    = (cw.ram_op == ptw_pkg::OP_READ);
  assign ram_raddr = ptw_pkg::table_word(frame_sel, ptw_pkg::va_index(va_q, cw.rd_level));

  ptw_ram #(
    .WIDTH(ptw_pkg::ENTRY_W),
    .DEPTH(ptw_pkg::STORE_WORDS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign missing    = !ram_rdata[ptw_pkg::PRESENT_BIT];
  assign load_fault = cw.check && missing;
  assign load_ok    = (cw.result != ptw_pkg::RES_NONE) && !load_fault;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= load_fault || load_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (load_fault) begin
      physical_address <= '0;
      fault            <= 1'b1;
      fault_level      <= cw.chk_level;
    end else if (load_ok) begin
      fault       <= 1'b0;
      fault_level <= '0;
      // The frame bits of the leaf entry go above the 12-bit page offset.
      if (cw.result == ptw_pkg::RES_LEAF) begin
        physical_address <= {ram_rdata[ptw_pkg::PA_W-1:ptw_pkg::FRAME_LO],
                             va_q[ptw_pkg::OFF_W-1:0]};
      end else begin
        physical_address <= '0;
      end
    end
  end

endmodule

// ===== hdl/four_level_page_table_walker.sv =====
// ----------------------------------------------------------------------------
// four_level_page_table_walker
// Four-level page-table walker with its own table-word store.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. A write item stores its
// word in the WRITE step. In a translation the four dependent entry reads
// through the store's single registered read port follow the accept cycle,
// and the leaf entry is checked in the cycle after its read. A walk stops at
// the first entry without the present bit. Each item gives one result word,
// shown for one cycle with done high, in the cycle after the item finishes;
// that same cycle may already accept the next item. The receiver cannot
// stall results. After reset the store is cleared one word a cycle, and busy
// stays high until every word is clear. The root register can be written at
// any time (cfg_ready is always high) but should only change while no
// translation is in flight.
module four_level_page_table_walker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        mode,
  input  logic [ptw_pkg::WADDR_W-1:0] word_address,
  input  logic [ptw_pkg::ENTRY_W-1:0] write_data,
  input  logic [ptw_pkg::VA_W-1:0]    virtual_address,
  output logic                        done,
  output logic [ptw_pkg::PA_W-1:0]    physical_address,
  output logic                        fault,
  output logic [1:0]                  fault_level,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [ptw_pkg::PA_W-1:0]    root_table_address
);

  ptw_pkg::ctrl_word_t  cw;
  ptw_pkg::seq_status_t status;
  logic                 accept;
  logic                 missing;
  logic                 clear_last;

  assign busy      = cw.busy;
  assign accept    = start && !cw.busy;
  assign cfg_ready = 1'b1;

  assign status.start      = start;
  assign status.mode       = mode;
  assign status.missing    = missing;
  assign status.clear_last = clear_last;

  ptw_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .status(status),
    .cw    (cw)
  );

  ptw_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .cw                (cw),
    .accept            (accept),
    .word_address      (word_address),
    .write_data        (write_data),
    .virtual_address   (virtual_address),
    .root_we           (cfg_valid && cfg_ready),
    .root_table_address(root_table_address),
    .missing           (missing),
    .clear_last        (clear_last),
    .done              (done),
    .physical_address  (physical_address),
    .fault             (fault),
    .fault_level       (fault_level)
  );

endmodule

// ===== hdl/ptw_checker.sv =====
// ----------------------------------------------------------------------------
// ptw_checker
// Port-level checks of the page-table walker, bound to the top level.
// ----------------------------------------------------------------------------
module ptw_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic                        done,
  input logic [ptw_pkg::PA_W-1:0]    physical_address,
  input logic                        fault,
  input logic [1:0]                  fault_level
);

  // A faulting walk never reports an address.
  a_fault_zero_pa: assert property (@(posedge clk) disable iff (rst)
    done && fault |-> physical_address == '0)
    else $error("fault result carries a nonzero address");

  // The level field only means something on a fault.
  a_level_clear: assert property (@(posedge clk) disable iff (rst)
    done && !fault |-> fault_level == 2'd0)
    else $error("fault level set without a fault");

  // Every accepted item makes the block busy in the cycle after it is taken.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("block not busy after accepting a word");

  // A result only follows a busy cycle.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without preceding work");

endmodule

bind four_level_page_table_walker ptw_checker u_ptw_checker (
  .clk             (clk),
  .rst             (rst),
  .start           (start),
  .busy            (busy),
  .done            (done),
  .physical_address(physical_address),
  .fault           (fault),
  .fault_level     (fault_level)
);

// ===== dv/ptw_result_checker.sv =====
// ----------------------------------------------------------------------------
// ptw_result_checker
// Result checker for the four-level page-table walker.
// ----------------------------------------------------------------------------
// Watches the item, result and root-register channels of the walker. It keeps
// its own copy of the table store and of the root register and computes the
// result of every accepted item. Each result word is compared field by field
// with the oldest expectation, and each mismatch is reported and counted.
// ----------------------------------------------------------------------------
package ptw_tb_pkg;

  typedef enum logic {
    MODE_WRITE = 1'b0,
    MODE_XLATE = 1'b1
  } item_mode_t;

endpackage

module ptw_result_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         busy,
  input  logic                         mode,
  input  logic [ptw_pkg::WADDR_W-1:0]  word_address,
  input  logic [ptw_pkg::ENTRY_W-1:0]  write_data,
  input  logic [ptw_pkg::VA_W-1:0]     virtual_address,
  input  logic                         done,
  input  logic [ptw_pkg::PA_W-1:0]     physical_address,
  input  logic                         fault,
  input  logic [1:0]                   fault_level,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [ptw_pkg::PA_W-1:0]     root_table_address,
  output int                           fail_count,
  output int                           pending,
  output int                           checked,
  output int                           walk_faults
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] FRAME_BITS = 64'h000F_FFFF_FFFF_F000;
  localparam logic [63:0] OFFSET_BITS = 64'h0000_0000_0000_0FFF;

  typedef struct packed {
    logic [ptw_pkg::PA_W-1:0] phys;
    logic                     fault;
    logic [1:0]               level;
  } xlate_t;

  logic [ptw_pkg::ENTRY_W-1:0] page_words [ptw_pkg::STORE_WORDS];
  logic [ptw_pkg::PA_W-1:0]    root_copy;
  xlate_t                      expected_xlate_q [$];

  // Up to four dependent reads; table word index wraps modulo the store size.
  function automatic xlate_t walk_tables(logic [ptw_pkg::VA_W-1:0] va);
    xlate_t      r;
    logic [63:0] tbl;
    logic [63:0] entry;
    logic [63:0] widx;
    logic [8:0]  idx;
    r = '0;
    tbl = {12'b0, root_copy};
    entry = '0;
    for (int lvl = 0; lvl < 4; lvl++) begin
      idx = 9'(va >> (39 - 9 * lvl));
      widx = ((tbl & FRAME_BITS) >> 3) + {55'b0, idx};
      entry = page_words[widx % ptw_pkg::STORE_WORDS];
      if (!entry[ptw_pkg::PRESENT_BIT]) begin
        r.fault = 1'b1;
        r.level = 2'(lvl);
        return r;
      end
      tbl = entry & FRAME_BITS;
    end
    r.phys = ptw_pkg::PA_W'((entry & FRAME_BITS) + ({16'b0, va} & OFFSET_BITS));
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    checked = 0;
    walk_faults = 0;
  end

  always @(posedge clk) begin
    xlate_t want;
    if (rst) begin
      foreach (page_words[i]) page_words[i] = '0;
      root_copy = '0;
      expected_xlate_q.delete();
    end else begin
      if (done) begin
        if (expected_xlate_q.size() == 0) begin
          report_mismatch("result word with nothing outstanding",
                          64'(physical_address), '0);
        end else begin
          want = expected_xlate_q.pop_front();
          checked++;
          if (fault) walk_faults++;
          if (physical_address !== want.phys)
            report_mismatch("physical_address", 64'(physical_address), 64'(want.phys));
          if (fault !== want.fault)
            report_mismatch("fault", 64'(fault), 64'(want.fault));
          if (fault_level !== want.level)
            report_mismatch("fault_level", 64'(fault_level), 64'(want.level));
        end
      end
      if (cfg_valid && cfg_ready) root_copy = root_table_address;
      if (start && !busy) begin
        if (mode == ptw_tb_pkg::MODE_WRITE) begin
          page_words[word_address % ptw_pkg::STORE_WORDS] = write_data;
          want = '0;
        end else begin
          want = walk_tables(virtual_address);
        end
        expected_xlate_q.push_back(want);
      end
    end
    pending = expected_xlate_q.size();
  end

endmodule

// ===== dv/four_level_page_table_walker_tb.sv =====
// ----------------------------------------------------------------------------
// four_level_page_table_walker_tb
// Top-level testbench of the four-level page-table walker.
// ----------------------------------------------------------------------------
// Drives table writes and translations: a short directed set first, then
// random page-table chains, broken chains and random noise under three root
// settings with varying sender gaps. The checker predicts and compares; this
// module only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module four_level_page_table_walker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PHASE_ITEMS = 510;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         start = 1'b0;
  logic                         busy;
  logic                         mode = ptw_tb_pkg::MODE_WRITE;
  logic [ptw_pkg::WADDR_W-1:0]  word_address = '0;
  logic [ptw_pkg::ENTRY_W-1:0]  write_data = '0;
  logic [ptw_pkg::VA_W-1:0]     virtual_address = '0;
  logic                         done;
  logic [ptw_pkg::PA_W-1:0]     physical_address;
  logic                         fault;
  logic [1:0]                   fault_level;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [ptw_pkg::PA_W-1:0]     root_table_address = '0;

  int                           fail_count;
  int                           pending;
  int                           checked;
  int                           walk_faults;
  int                           items_sent = 0;
  int                           xlates_sent = 0;
  int                           gap_pct = 0;
  logic [ptw_pkg::PA_W-1:0]     root_now = '0;

  four_level_page_table_walker dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .mode             (mode),
    .word_address     (word_address),
    .write_data       (write_data),
    .virtual_address  (virtual_address),
    .done             (done),
    .physical_address (physical_address),
    .fault            (fault),
    .fault_level      (fault_level),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .root_table_address (root_table_address)
  );

  ptw_result_checker checker_i (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .mode             (mode),
    .word_address     (word_address),
    .write_data       (write_data),
    .virtual_address  (virtual_address),
    .done             (done),
    .physical_address (physical_address),
    .fault            (fault),
    .fault_level      (fault_level),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .root_table_address (root_table_address),
    .fail_count       (fail_count),
    .pending          (pending),
    .checked          (checked),
    .walk_faults      (walk_faults)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_word(input ptw_tb_pkg::item_mode_t m,
                           input logic [ptw_pkg::WADDR_W-1:0] wa,
                           input logic [ptw_pkg::ENTRY_W-1:0] wd,
                           input logic [ptw_pkg::VA_W-1:0] va);
    if ($urandom_range(99) < gap_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    mode = m;
    word_address = wa;
    write_data = wd;
    virtual_address = va;
    start = 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
    items_sent++;
    if (m == ptw_tb_pkg::MODE_XLATE) xlates_sent++;
  endtask

  task automatic table_write(input logic [ptw_pkg::WADDR_W-1:0] wa,
                             input logic [ptw_pkg::ENTRY_W-1:0] wd);
    send_word(ptw_tb_pkg::MODE_WRITE, wa, wd, ptw_pkg::VA_W'(rand64()));
  endtask

  task automatic translate(input logic [ptw_pkg::VA_W-1:0] va);
    send_word(ptw_tb_pkg::MODE_XLATE, ptw_pkg::WADDR_W'($urandom), rand64(), va);
  endtask

  task automatic wait_drained();
    start = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic set_root(input logic [ptw_pkg::PA_W-1:0] value);
    wait_drained();
    cfg_valid = 1'b1;
    root_table_address = value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    root_table_address = ptw_pkg::PA_W'(rand64());
    root_now = value;
  endtask

  // Writes the entries a walk of a random address reads, then translates it.
  // A whole chain writes all four; a broken one stops at a not-present level.
  task automatic walk_chain(input bit broken);
    logic [ptw_pkg::VA_W-1:0]    va;
    logic [ptw_pkg::FRAME_W-1:0] frame;
    logic [ptw_pkg::ENTRY_W-1:0] entry;
    logic [ptw_pkg::IDX_W-1:0]   idx;
    int                          cut;
    va = ptw_pkg::VA_W'(rand64());
    frame = root_now[ptw_pkg::PA_W-1:ptw_pkg::FRAME_LO];
    cut = broken ? $urandom_range(0, 3) : 4;
    for (int lvl = 0; lvl < 4; lvl++) begin
      idx = ptw_pkg::IDX_W'(va >> (39 - 9 * lvl));
      entry = rand64();
      entry[ptw_pkg::PRESENT_BIT] = (lvl != cut);
      table_write({frame[2:0], idx}, entry);
      frame = entry[ptw_pkg::PA_W-1:ptw_pkg::FRAME_LO];
      if (lvl == cut) break;
    end
    translate(va);
    if ($urandom_range(1))
      translate({va[ptw_pkg::VA_W-1:ptw_pkg::OFF_W], ptw_pkg::OFF_W'($urandom)});
    if ($urandom_range(3) == 0)
      translate({va[ptw_pkg::VA_W-1:21], 9'($urandom), 12'($urandom)});
  endtask

  task automatic random_phase(input int target);
    int goal;
    goal = items_sent + target;
    while (items_sent < goal) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: walk_chain(1'b0);
        6:                walk_chain(1'b1);
        7:                table_write(ptw_pkg::WADDR_W'($urandom), rand64());
        default:          translate(ptw_pkg::VA_W'(rand64()));
      endcase
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    set_root('0);

    // Directed part: empty store, a hand-built chain with all-ones frames,
    // a miss at each level, ignored bits and word wrap.
    translate('0);
    translate('1);
    table_write(12'd0, '1);
    table_write(12'd3584, 64'h0000_0000_0000_1001);
    table_write(12'd512, 64'hFFF0_0000_0000_2FFF);
    table_write(12'd1024, 64'h000F_FFFF_FFFF_F001);
    translate(48'h0000_0000_0FFF);
    translate(48'h0000_0000_0000);
    translate({9'd0, 9'd1, 30'd0});
    translate({18'd0, 9'd1, 21'd0});
    translate({27'd0, 9'd1, 12'hABC});
    send_word(ptw_tb_pkg::MODE_WRITE, '1, '1, '1);
    send_word(ptw_tb_pkg::MODE_XLATE, '1, '1, 48'h0000_0000_0123);
    table_write(12'd3584, 64'hFFFF_FFFF_FFFF_FFFE);
    translate(48'h0000_0000_0000);
    table_write(12'd3584, 64'h0000_0000_0000_1001);
    set_root('1);
    translate('0);
    translate('1);

    gap_pct = 37;
    random_phase(PHASE_ITEMS);
    set_root(ptw_pkg::PA_W'(rand64()));
    gap_pct = 65;
    random_phase(PHASE_ITEMS);
    set_root(ptw_pkg::PA_W'(rand64()));
    gap_pct = 0;
    random_phase(PHASE_ITEMS);

    wait_drained();
    repeat (20) @(posedge clk);
    $display("Sent %0d items (%0d translations) under four root settings.",
             items_sent, xlates_sent);
    $display("Checked %0d result words, %0d of them walk faults; %0d mismatches.",
             checked, walk_faults, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d result words outstanding.", pending);
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/ptw_pkg.sv
hdl/ptw_ram.sv
hdl/ptw_seq.sv
hdl/ptw_dp.sv
hdl/four_level_page_table_walker.sv
hdl/ptw_checker.sv
dv/ptw_result_checker.sv
dv/four_level_page_table_walker_tb.sv
